// ===== rtl/srtf_single_cpu_scheduler_unit_defines.svh =====
// assertion macros for the srtf scheduler unit
// used by the top level; expects signals named clk and arst_n in scope
`ifndef SRTF_SINGLE_CPU_SCHEDULER_UNIT_DEFINES_SVH
`define SRTF_SINGLE_CPU_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define SRTF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("srtf invariant failed");

// antecedent implies consequent in the same cycle
`define SRTF_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srtf implication failed");

// antecedent implies consequent in the next cycle
`define SRTF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srtf next-cycle check failed");

`else

`define SRTF_ASSERT_ALWAYS(lbl, cond)
`define SRTF_ASSERT_IMPLY(lbl, ante, cons)
`define SRTF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/srtf_pkg.sv =====
// shared types and codes for the srtf scheduler unit
// no dependencies
package srtf_pkg;

	// event codes on the result stream
	localparam logic [1:0] EV_RUNNING  = 2'd0;
	localparam logic [1:0] EV_FINISHED = 2'd1;
	localparam logic [1:0] EV_REJECTED = 2'd2;

	// command codes on the input stream
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// job record held by one chain cell (slot tag travels beside it)
	typedef struct packed {
		logic [31:0] job;
		logic [31:0] arrival;
		logic [31:0] remaining;
	} entry_t;

	// per-cycle chain operation
	typedef struct packed {
		logic insert;
		logic dec;
		logic shift;
	} cell_op_t;

	// one result item
	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] event_time;
		logic [31:0] event_job;
		logic [31:0] time_left;
		logic [15:0] jobs_left;
		logic [31:0] turnaround;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/srtf_cell.sv =====
// one cell of the sorted job chain: holds a job, compares it to an incoming one
// and takes its left or right neighbor on insert or removal; uses srtf_pkg
module srtf_cell import srtf_pkg::*; #(
	parameter int SLOT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_op_t          op,
	input  entry_t            new_entry,
	input  logic [SLOT_W-1:0] new_slot,
	input  logic              left_occ,
	input  logic              left_lt,
	input  entry_t            left_entry,
	input  logic [SLOT_W-1:0] left_slot,
	input  logic              right_occ,
	input  entry_t            right_entry,
	input  logic [SLOT_W-1:0] right_slot,
	output logic              occ,
	output logic              lt,
	output entry_t            entry,
	output logic [SLOT_W-1:0] slot
);

	logic              occ_q;
	entry_t            entry_q;
	logic [SLOT_W-1:0] slot_q;

	// key order: remaining time, then job id, then slot index
	assign lt = occ_q &&
		({entry_q.remaining, entry_q.job, slot_q} <
		 {new_entry.remaining, new_entry.job, new_slot});

	assign occ   = occ_q;
	assign entry = entry_q;
	assign slot  = slot_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (op.insert) begin
			if (!lt) begin
				occ_q <= left_lt ? 1'b1 : left_occ;
			end
		end else if (op.shift) begin
			occ_q <= right_occ;
		end
	end

	// payload: insert shifts right, removal shifts left, head decrements
	always_ff @(posedge clk) begin
		if (op.insert) begin
			if (!lt) begin
				if (left_lt) begin
					entry_q <= new_entry;
					slot_q  <= new_slot;
				end else begin
					entry_q <= left_entry;
					slot_q  <= left_slot;
				end
			end
		end else if (op.shift) begin
			entry_q <= right_entry;
			slot_q  <= right_slot;
		end else if (op.dec) begin
			entry_q.remaining <= entry_q.remaining - 32'd1;
		end
	end

endmodule

// ===== rtl/srtf_out_fifo.sv =====
// small result queue between the scheduler core and the output stream
// uses srtf_pkg
module srtf_out_fifo import srtf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  out_item_t          push_item,
	input  logic               pop,
	output logic               valid,
	output out_item_t          item,
	output logic [FIFO_CW-1:0] count
);

	out_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_pop;

	assign valid  = (count_q != '0);
	assign item   = mem_q[rd_ptr_q];
	assign count  = count_q;
	assign do_pop = pop && valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/srtf_single_cpu_scheduler_unit.sv =====
// Preemptive shortest-remaining-time-first scheduler for one processor.
// Input stream: s_axis_tuser is the command (arrive or tick), s_axis_tdata
// carries job id and service time. Output stream: one transfer per event
// (running, finished, rejected), m_axis_tlast marks the last event of an input.
// cfg_wr_en/cfg_wr_data set the total job count used for the jobs-left figure.
// Jobs sit in a chain of MAX_JOBS cells kept sorted by remaining time, job id
// and slot index, so the head is always the job to run; an arrival is written
// into place by all cells together, a finished job leaves by shifting the
// whole chain left one cell. An item is accepted in ST_IDLE, then ST_EXEC
// does the chain update; a tick that finishes a job goes on to ST_FIN, which
// builds the finished event. Results are registered in a queue before m_axis.
// A 4-entry result queue decouples the sides: s_axis_tready drops only while
// an item is in work or the queue has fewer than two free entries.
// Reset (arst_n) empties the chain, clears time, counters and the total at
// once; no clearing pass is needed. A stalled receiver only fills the queue.
// The user writes configuration only while idle; the block does not check it.
// Depends on srtf_pkg, srtf_cell, srtf_out_fifo and the defines header.
`include "srtf_single_cpu_scheduler_unit_defines.svh"

module srtf_single_cpu_scheduler_unit import srtf_pkg::*; #(
	parameter int MAX_JOBS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// config
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,    // total_jobs
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // job_id[31:0], service_time[63:32]
	input  logic         s_axis_tuser,   // cmd
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata,   // event_res[1:0], event_time[33:2],
	                                     // event_job[65:34], time_left[97:66],
	                                     // jobs_left[113:98], turnaround[145:114],
	                                     // zero pad[151:146]
	output logic         m_axis_tlast    // last
);

	localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

	state_t            state_q, state_nxt;

	// accepted item
	logic              cmd_s1;
	logic [31:0]       job_s1;
	logic [31:0]       svc_s1;

	logic [15:0]       total_jobs_q;
	logic [31:0]       now_q;
	logic [15:0]       finished_count_q;
	logic              run_valid_q;
	logic [SLOT_W-1:0] running_slot_q;
	logic [31:0]       fin_job_q;
	logic [31:0]       fin_arr_q;
	logic [MAX_JOBS-1:0] slot_valid_q;
	logic [SLOT_W-1:0] free_idx, free_idx_q;

	// chain signals
	logic              cell_occ   [MAX_JOBS];
	logic              cell_lt    [MAX_JOBS];
	entry_t            cell_entry [MAX_JOBS];
	logic [SLOT_W-1:0] cell_slot  [MAX_JOBS];
	cell_op_t          chain_op;
	entry_t            new_entry;

	// control outputs of the state machine
	logic              accept;
	logic              push;
	out_item_t         push_item;
	logic              set_valid, clr_valid;
	logic              now_inc, run_set, run_clr, fin_inc, fin_latch;
	logic              table_full;
	logic              need_run, head_done;
	logic [15:0]       jobs_left;

	// result queue
	logic              fifo_valid;
	out_item_t         fifo_item;
	logic [FIFO_CW-1:0] fifo_count;

	assign table_full = &slot_valid_q;
	assign need_run   = !run_valid_q || (running_slot_q != cell_slot[0]);
	assign head_done  = (cell_entry[0].remaining == 32'd1);
	assign jobs_left  = (total_jobs_q > finished_count_q) ?
		(total_jobs_q - finished_count_q) : 16'd0;
	assign accept     = s_axis_tvalid && s_axis_tready;

	assign new_entry.job       = job_s1;
	assign new_entry.arrival   = now_q;
	assign new_entry.remaining = svc_s1;

	// lowest free slot, registered each cycle
	always_comb begin
		free_idx = '0;
		for (int i = MAX_JOBS - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and control
	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		push          = 1'b0;
		push_item     = '0;
		chain_op      = '0;
		set_valid     = 1'b0;
		clr_valid     = 1'b0;
		now_inc       = 1'b0;
		run_set       = 1'b0;
		run_clr       = 1'b0;
		fin_inc       = 1'b0;
		fin_latch     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
				if (s_axis_tvalid && s_axis_tready) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
				if (cmd_s1 == CMD_ARRIVE) begin
					if (svc_s1 != 32'd0) begin
						if (table_full) begin
							push                 = 1'b1;
							push_item.event_res  = EV_REJECTED;
							push_item.event_time = now_q;
							push_item.event_job  = job_s1;
							push_item.last       = 1'b1;
						end else begin
							chain_op.insert = 1'b1;
							set_valid       = 1'b1;
						end
					end
				end else begin
					now_inc = 1'b1;
					if (cell_occ[0]) begin
						if (need_run) begin
							push                 = 1'b1;
							push_item.event_res  = EV_RUNNING;
							push_item.event_time = now_q;
							push_item.event_job  = cell_entry[0].job;
							push_item.time_left  = cell_entry[0].remaining;
							push_item.last       = !head_done;
							run_set              = 1'b1;
						end
						if (head_done) begin
							chain_op.shift = 1'b1;
							clr_valid      = 1'b1;
							run_clr        = 1'b1;
							fin_inc        = 1'b1;
							fin_latch      = 1'b1;
							state_nxt      = ST_FIN;
						end else begin
							chain_op.dec = 1'b1;
						end
					end
				end
			end
			ST_FIN: begin
				push                 = 1'b1;
				push_item.event_res  = EV_FINISHED;
				push_item.event_time = now_q;
				push_item.event_job  = fin_job_q;
				push_item.jobs_left  = jobs_left;
				push_item.turnaround = now_q - fin_arr_q;
				push_item.last       = 1'b1;
				state_nxt            = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_jobs_q     <= '0;
			now_q            <= '0;
			finished_count_q <= '0;
			run_valid_q      <= 1'b0;
			running_slot_q   <= '0;
			slot_valid_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				total_jobs_q <= cfg_wr_data;
			end
			if (now_inc) begin
				now_q <= now_q + 32'd1;
			end
			if (fin_inc && (finished_count_q != 16'hFFFF)) begin
				finished_count_q <= finished_count_q + 16'd1;
			end
			if (run_clr) begin
				run_valid_q <= 1'b0;
			end else if (run_set) begin
				run_valid_q    <= 1'b1;
				running_slot_q <= cell_slot[0];
			end
			if (set_valid) begin
				slot_valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_valid) begin
				slot_valid_q[cell_slot[0]] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		free_idx_q <= free_idx;
		if (accept) begin
			cmd_s1 <= s_axis_tuser;
			job_s1 <= s_axis_tdata[31:0];
			svc_s1 <= s_axis_tdata[63:32];
		end
		if (fin_latch) begin
			fin_job_q <= cell_entry[0].job;
			fin_arr_q <= cell_entry[0].arrival;
		end
	end

	// sorted chain of job cells, head at index 0
	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		cell_op_t          op_i;
		logic              l_occ, l_lt, r_occ;
		entry_t            l_entry, r_entry;
		logic [SLOT_W-1:0] l_slot, r_slot;

		assign op_i.insert = chain_op.insert;
		assign op_i.shift  = chain_op.shift;
		if (i == 0) begin : g_head
			assign op_i.dec = chain_op.dec;
			assign l_occ    = 1'b0;
			assign l_lt     = 1'b1;
			assign l_entry  = '0;
			assign l_slot   = '0;
		end else begin : g_body
			assign op_i.dec = 1'b0;
			assign l_occ    = cell_occ[i-1];
			assign l_lt     = cell_lt[i-1];
			assign l_entry  = cell_entry[i-1];
			assign l_slot   = cell_slot[i-1];
		end
		if (i == MAX_JOBS - 1) begin : g_tail
			assign r_occ   = 1'b0;
			assign r_entry = '0;
			assign r_slot  = '0;
		end else begin : g_mid
			assign r_occ   = cell_occ[i+1];
			assign r_entry = cell_entry[i+1];
			assign r_slot  = cell_slot[i+1];
		end

		srtf_cell #(
			.SLOT_W (SLOT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op_i),
			.new_entry   (new_entry),
			.new_slot    (free_idx_q),
			.left_occ    (l_occ),
			.left_lt     (l_lt),
			.left_entry  (l_entry),
			.left_slot   (l_slot),
			.right_occ   (r_occ),
			.right_entry (r_entry),
			.right_slot  (r_slot),
			.occ         (cell_occ[i]),
			.lt          (cell_lt[i]),
			.entry       (cell_entry[i]),
			.slot        (cell_slot[i])
		);
	end

	// result queue and output packing
	srtf_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (m_axis_tready),
		.valid     (fifo_valid),
		.item      (fifo_item),
		.count     (fifo_count)
	);

	assign m_axis_tvalid = fifo_valid;
	assign m_axis_tlast  = fifo_item.last;
	assign m_axis_tdata  = {6'd0, fifo_item.turnaround, fifo_item.jobs_left,
		fifo_item.time_left, fifo_item.event_job, fifo_item.event_time,
		fifo_item.event_res};

	// checks
	logic [MAX_JOBS-1:0] occ_vec;
	always_comb begin
		for (int i = 0; i < MAX_JOBS; i++) begin
			occ_vec[i] = cell_occ[i];
		end
	end

	`SRTF_ASSERT_ALWAYS(a_occ_matches_slots, $countones(occ_vec) == $countones(slot_valid_q))
	`SRTF_ASSERT_IMPLY(a_head_nonzero, cell_occ[0], cell_entry[0].remaining != 32'd0)
	`SRTF_ASSERT_IMPLY(a_running_is_stored, run_valid_q, slot_valid_q[running_slot_q])
	`SRTF_ASSERT_IMPLY(a_no_queue_overflow, push, fifo_count < FIFO_CW'(FIFO_DEPTH) || m_axis_tready)

endmodule

// ===== sim/srtf_single_cpu_scheduler_unit_checker.sv =====
// result checker for the srtf scheduler unit: mirrors the job table, predicts events
// from each input transfer and compares every output transfer against them
// depends on srtf_pkg
module srtf_single_cpu_scheduler_unit_checker import srtf_pkg::*; #(
	parameter int TABLE_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [151:0] m_axis_tdata,
	input  logic         m_axis_tlast,
	output int           errors,
	output int           pending,
	output int           held,
	output int           work_count
);

	// mirror of the job table and scheduler state
	logic        slot_used [TABLE_SIZE];
	logic [31:0] slot_id   [TABLE_SIZE];
	logic [31:0] slot_arr  [TABLE_SIZE];
	logic [31:0] slot_rem  [TABLE_SIZE];
	logic [31:0] now_t;
	int          run_slot;
	logic        run_on;
	logic [15:0] done_cnt;
	logic [15:0] total_cfg;

	// events still owed by the block, oldest first
	out_item_t   events_due [$];
	int          err_n;
	int          held_n;
	int          work_n;

	function automatic out_item_t make_event(input logic [1:0] res, input logic [31:0] t,
			input logic [31:0] job, input logic [31:0] tl, input logic [15:0] jl,
			input logic [31:0] ta, input logic lst);
		out_item_t ev;
		ev.event_res  = res;
		ev.event_time = t;
		ev.event_job  = job;
		ev.time_left  = tl;
		ev.jobs_left  = jl;
		ev.turnaround = ta;
		ev.last       = lst;
		return ev;
	endfunction

	// watch both streams and the config port
	always @(posedge clk or negedge arst_n) begin : watch
		logic        cmd;
		logic [31:0] id;
		logic [31:0] svc;
		logic [15:0] left;
		int          free;
		int          sel;
		out_item_t   got;
		out_item_t   want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				slot_used[i] = 1'b0;
			end
			now_t     = '0;
			run_slot  = 0;
			run_on    = 1'b0;
			done_cnt  = '0;
			total_cfg = '0;
			events_due.delete();
			err_n     = 0;
			held_n    = 0;
			work_n    = 0;
		end else begin
			if (cfg_wr_en) begin
				total_cfg = cfg_wr_data;
			end

			// input transfer: update the mirror and queue the events it causes
			if (s_axis_tvalid && s_axis_tready) begin
				cmd = s_axis_tuser;
				id  = s_axis_tdata[31:0];
				svc = s_axis_tdata[63:32];
				if (cmd == CMD_ARRIVE) begin
					// zero service time is dropped silently
					if (svc != 0) begin
						work_n++;
						free = -1;
						for (int i = 0; i < TABLE_SIZE; i++) begin
							if (!slot_used[i] && free < 0)
								free = i;
						end
						if (free >= 0) begin
							slot_used[free] = 1'b1;
							slot_id[free]   = id;
							slot_arr[free]  = now_t;
							slot_rem[free]  = svc;
							held_n++;
						end else begin
							events_due.push_back(make_event(EV_REJECTED, now_t, id,
								'0, '0, '0, 1'b1));
						end
					end
				end else begin
					// least remaining time, then lower id, then lower slot
					sel = -1;
					for (int i = 0; i < TABLE_SIZE; i++) begin
						if (slot_used[i] && (sel < 0 || slot_rem[i] < slot_rem[sel] ||
								(slot_rem[i] == slot_rem[sel] && slot_id[i] < slot_id[sel])))
							sel = i;
					end
					if (sel < 0) begin
						now_t = now_t + 1;
					end else begin
						work_n++;
						if (!run_on || run_slot != sel) begin
							events_due.push_back(make_event(EV_RUNNING, now_t, slot_id[sel],
								slot_rem[sel], '0, '0, slot_rem[sel] != 1));
							run_slot = sel;
							run_on   = 1'b1;
						end
						slot_rem[sel] = slot_rem[sel] - 1;
						now_t = now_t + 1;
						if (slot_rem[sel] == 0) begin
							slot_used[sel] = 1'b0;
							held_n--;
							run_on = 1'b0;
							if (done_cnt != 16'hFFFF)
								done_cnt++;
							left = (total_cfg > done_cnt) ? total_cfg - done_cnt : 16'd0;
							events_due.push_back(make_event(EV_FINISHED, now_t, slot_id[sel],
								'0, left, now_t - slot_arr[sel], 1'b1));
						end
					end
				end
			end

			// output transfer: compare with the oldest owed event
			if (m_axis_tvalid && m_axis_tready) begin
				got = make_event(m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
					m_axis_tdata[97:66], m_axis_tdata[113:98], m_axis_tdata[145:114],
					m_axis_tlast);
				if (events_due.size() == 0) begin
					err_n++;
					if (err_n <= 10)
						$display("%0t: unexpected event res=%0d time=%0d job=%0h",
							$time, got.event_res, got.event_time, got.event_job);
				end else begin
					want = events_due.pop_front();
					if (got !== want || m_axis_tdata[151:146] !== 6'd0) begin
						err_n++;
						if (err_n <= 10) begin
							$display("%0t: expected res=%0d time=%0d job=%0h tl=%0d jl=%0d ta=%0d last=%0b",
								$time, want.event_res, want.event_time, want.event_job,
								want.time_left, want.jobs_left, want.turnaround, want.last);
							$display("%0t: actual   res=%0d time=%0d job=%0h tl=%0d jl=%0d ta=%0d last=%0b pad=%0h",
								$time, got.event_res, got.event_time, got.event_job,
								got.time_left, got.jobs_left, got.turnaround, got.last,
								m_axis_tdata[151:146]);
						end
					end
				end
			end
		end
		errors     <= err_n;
		pending    <= events_due.size();
		held       <= held_n;
		work_count <= work_n;
	end

endmodule

// ===== sim/srtf_single_cpu_scheduler_unit_tb.sv =====
// testbench top for the srtf scheduler unit: clock, reset, job and tick stimulus
// with random backpressure; checking sits in srtf_single_cpu_scheduler_unit_checker
// depends on srtf_pkg, the checker and the unit
module srtf_single_cpu_scheduler_unit_tb import srtf_pkg::*;;

	localparam int TABLE_SIZE  = 64;
	localparam int CLK_HALF    = 6;
	localparam int WORK_TARGET = 1400;

	typedef enum int {
		BURST_MIXED,
		BURST_FLOOD,
		BURST_NOISE
	} burst_kind_t;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         cfg_wr_en     = 1'b0;
	logic [15:0]  cfg_wr_data   = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata  = '0;   // job_id[31:0], service_time[63:32]
	logic         s_axis_tuser  = 1'b0; // cmd
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;         // event_res, event_time, event_job, time_left,
	                                    // jobs_left, turnaround, zero pad
	logic         m_axis_tlast;         // last

	int errors;
	int pending;
	int held;
	int work_count;
	int src_idle  = 22;
	int sink_idle = 81;

	always begin
		clk = 1'b1;
		#(CLK_HALF);
		clk = 1'b0;
		#(CLK_HALF);
	end

	srtf_single_cpu_scheduler_unit #(
		.MAX_JOBS(TABLE_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	srtf_single_cpu_scheduler_unit_checker #(
		.TABLE_SIZE(TABLE_SIZE)
	) sched_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors),
		.pending(pending),
		.held(held),
		.work_count(work_count)
	);

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic push_item(input logic cmd, input logic [31:0] id, input logic [31:0] svc);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {svc, id};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// wait until the block is quiet, then write the job total
	task automatic set_total(input logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// one well-formed or noisy sequence of arrivals and ticks
	task automatic run_burst(input burst_kind_t kind);
		int          work;
		int          n;
		logic [31:0] id;
		logic [31:0] svc;
		case (kind)
			BURST_MIXED: begin
				// a few arrivals with ticks woven in, then roughly enough ticks to drain
				work = 0;
				n = $urandom_range(1, 6);
				repeat (n) begin
					id = $urandom_range(1) ? $urandom_range(7) : $urandom();
					case ($urandom_range(19))
						0:       svc = 0;
						1, 2, 3: svc = $urandom_range(5, 40);
						default: svc = $urandom_range(1, 4);
					endcase
					work += svc;
					push_item(CMD_ARRIVE, id, svc);
					repeat ($urandom_range(2)) push_item(CMD_TICK, $urandom(), $urandom());
				end
				repeat ($urandom_range(work / 2, work + 3))
					push_item(CMD_TICK, $urandom(), $urandom());
			end
			BURST_FLOOD: begin
				// fill the table, hit it with arrivals that bounce, then run it dry
				while (held < TABLE_SIZE) begin
					id = $urandom_range(1) ? $urandom_range(15) : $urandom();
					push_item(CMD_ARRIVE, id, $urandom_range(1, 3));
				end
				push_item(CMD_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				push_item(CMD_ARRIVE, 32'h0, 32'h1);
				repeat ($urandom_range(2, 8)) push_item(CMD_ARRIVE, $urandom(), $urandom());
				while (held != 0) push_item(CMD_TICK, $urandom(), $urandom());
			end
			default: begin
				// stray ticks, dropped arrivals and lone short jobs
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(2))
						0:       push_item(CMD_TICK, $urandom(), $urandom());
						1:       push_item(CMD_ARRIVE, $urandom(), 32'h0);
						default: push_item(CMD_ARRIVE, $urandom(), $urandom_range(1, 4));
					endcase
				end
			end
		endcase
	endtask

	// stimulus and verdict
	initial begin
		int          goal;
		int          pick;
		bit          mid_done;
		burst_kind_t kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_total(16'd0);

		// directed: idle tick, dropped arrival, ties, duplicate ids, preemption
		push_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_ARRIVE, 32'hFFFF_FFFF, 32'h0);
		push_item(CMD_ARRIVE, 32'd5, 32'd3);
		push_item(CMD_ARRIVE, 32'hFFFF_FFFF, 32'd3);
		push_item(CMD_ARRIVE, 32'd2, 32'd3);
		push_item(CMD_ARRIVE, 32'd2, 32'd3);
		push_item(CMD_ARRIVE, 32'd0, 32'd1);
		// shortest job starts and finishes in one tick, jobs left clamps at zero
		push_item(CMD_TICK, 32'h0, 32'h0);
		push_item(CMD_TICK, 32'h0, 32'h0);
		push_item(CMD_ARRIVE, 32'd9, 32'd1);
		repeat (13) push_item(CMD_TICK, 32'hFFFF_FFFF, 32'h0);

		// random phases, one per idle pattern
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle  = 22;
					sink_idle = 81;
					set_total(16'hFFFF);
				end
				1: begin
					src_idle  = 81;
					sink_idle = 22;
					set_total(16'($urandom_range(300, 1500)));
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
					set_total(16'($urandom_range(65535)));
				end
			endcase
			if (phase == 0)
				run_burst(BURST_FLOOD);
			goal = WORK_TARGET * (phase + 1) / 3;
			mid_done = 1'b0;
			while (work_count < goal) begin
				if (!mid_done && work_count >= goal - WORK_TARGET / 6) begin
					set_total(16'($urandom_range(2000)));
					mid_done = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 3)
					kind = BURST_FLOOD;
				else if (pick < 88)
					kind = BURST_MIXED;
				else
					kind = BURST_NOISE;
				run_burst(kind);
			end
		end

		// drain and settle
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#(2 * CLK_HALF * 600000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
